@@ src/ecg_beat_detector_unit_assert.svh @@
// Assertion macros used by the file that checks this block.
`ifndef ECG_BEAT_DETECTOR_UNIT_ASSERT_SVH
`define ECG_BEAT_DETECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECG_BD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECG_BD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ecg_bd_pkg.sv @@
package ecg_bd_pkg;

  // Ring of recent samples.
  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SMP_W      = 8;
  localparam int SUM_W      = SMP_W + PTR_W;

  // Mean by reciprocal multiplication, exact for every SUM_W-bit sum.
  localparam int AVG_SHIFT  = SUM_W + PTR_W;
  localparam int RECIP_W    = SUM_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << AVG_SHIFT) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W     = SUM_W + RECIP_W;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int BPM_W      = 8;
  localparam int LEVEL_W    = 5;
  localparam int OFFSET_W   = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLED    = 8'd1;
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET         = 8'd10;

  // BPM divider.
  localparam int DIV_W   = 16;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] BPM_NUM = 16'd60000;
  localparam logic [BPM_W-1:0] BPM_MAX = 8'd255;

  // Heart level steps and idle thresholds.
  localparam logic [LEVEL_W-1:0] LEVEL_BEAT = 5'd20;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 5'd15;
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = 5'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 5'd5;
  localparam logic [7:0] IDLE_BUZZ_OFF = 8'd3;
  localparam logic [7:0] IDLE_HIGH     = 8'd5;
  localparam logic [7:0] IDLE_MID      = 8'd8;
  localparam logic [7:0] IDLE_MAX      = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RING,
    S_MUL,
    S_DECIDE,
    S_BRANCH,
    S_DIV,
    S_OUT
  } ecg_bd_state_t;

  typedef struct packed {
    logic load_in;
    logic ring_upd;
    logic mul_ld;
    logic decide;
    logic div_start;
    logic commit;
  } ecg_bd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } ecg_bd_sts_t;

endpackage

@@ src/ecg_bd_ram.sv @@
module ecg_bd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/ecg_bd_div.sv @@
module ecg_bd_div
  import ecg_bd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  // Restoring division of the BPM constant, one quotient bit per cycle.
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]    rem_r;
  logic [DIV_W-1:0]  qr_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem_r[DIV_W-1:0], qr_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qr_r  <= BPM_NUM;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      qr_r  <= {qr_r[DIV_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = qr_r;

endmodule

@@ src/ecg_bd_datapath.sv @@
module ecg_bd_datapath
  import ecg_bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ecg_bd_cmd_t           cmd,
  output ecg_bd_sts_t           sts,
  output logic [DIV_W-1:0]      div_den,
  input  logic [DIV_W-1:0]      div_quo,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // Configuration.
  logic [OFFSET_W-1:0] offset_r;
  logic                sound_r;

  // Ring state.
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [RING_DEPTH-1:0] ring_valid_r;
  logic [SMP_W-1:0]      ram_rdata;
  logic [SMP_W-1:0]      old_smp;

  // Detector state.
  logic              armed_r, armed_nxt;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [7:0]        idle_r, idle_nxt;
  logic [BPM_W-1:0]  bpm_r, bpm_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic              buzz_r, buzz_nxt;

  // Per-item working registers.
  logic [SMP_W-1:0]  smp_r;
  logic [TIME_W-1:0] time_r;
  logic [PROD_W-1:0] prod_r;
  logic [SMP_W-1:0]  avg_r;
  logic [TIME_W-1:0] delta_r;
  logic              beat_r;
  logic              below_r;

  logic [SMP_W-1:0]  avg_w;
  logic [SMP_W:0]    thr_w;
  logic              beat_w;
  logic              below_w;
  logic [BPM_W-1:0]  bpm_beat;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  ecg_bd_ram #(
    .WIDTH(SMP_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.ring_upd),
    .waddr(ptr_r),
    .wdata(smp_r),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  // Entries never written are masked by the valid bits so that they read as zero.
  assign old_smp = ring_valid_r[ptr_r] ? ram_rdata : '0;
  assign sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
  assign ptr_nxt = (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  assign avg_w   = prod_r[AVG_SHIFT +: SMP_W];
  assign thr_w   = {1'b0, avg_w} + {1'b0, offset_r};
  assign beat_w  = armed_r && ({1'b0, smp_r} > thr_w);
  assign below_w = smp_r < avg_w;

  assign div_den = delta_r[DIV_W-1:0];
  assign sts.need_div = beat_r && (delta_r != '0) && (delta_r[TIME_W-1:DIV_W] == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    if (delta_r == '0) begin
      bpm_beat = BPM_MAX;
    end else if (delta_r[TIME_W-1:DIV_W] != '0) begin
      bpm_beat = '0;
    end else if (div_quo[DIV_W-1:BPM_W] != '0) begin
      bpm_beat = BPM_MAX;
    end else begin
      bpm_beat = div_quo[BPM_W-1:0];
    end
  end

  always_comb begin
    armed_nxt     = armed_r;
    last_time_nxt = last_time_r;
    idle_nxt      = idle_r;
    bpm_nxt       = bpm_r;
    level_nxt     = level_r;
    buzz_nxt      = buzz_r;
    if (beat_r) begin
      bpm_nxt       = bpm_beat;
      level_nxt     = LEVEL_BEAT;
      buzz_nxt      = sound_r;
      last_time_nxt = time_r;
      idle_nxt      = '0;
      armed_nxt     = 1'b0;
    end else if (below_r) begin
      if (idle_r < IDLE_BUZZ_OFF) begin
        buzz_nxt = 1'b0;
      end else if (idle_r < IDLE_HIGH) begin
        level_nxt = LEVEL_HIGH;
      end else if (idle_r < IDLE_MID) begin
        level_nxt = LEVEL_MID;
      end else begin
        level_nxt = LEVEL_LOW;
      end
      armed_nxt = 1'b1;
      if (idle_r != IDLE_MAX) begin
        idle_nxt = idle_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= OFFSET_RESET;
      sound_r      <= 1'b0;
      ptr_r        <= '0;
      sum_r        <= '0;
      ring_valid_r <= '0;
      armed_r      <= 1'b1;
      last_time_r  <= '0;
      idle_r       <= '0;
      bpm_r        <= '0;
      level_r      <= '0;
      buzz_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_THRESHOLD_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
          REG_SOUND_ENABLED:    sound_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.ring_upd) begin
        ptr_r               <= ptr_nxt;
        sum_r               <= sum_nxt;
        ring_valid_r[ptr_r] <= 1'b1;
      end
      if (cmd.commit) begin
        armed_r     <= armed_nxt;
        last_time_r <= last_time_nxt;
        idle_r      <= idle_nxt;
        bpm_r       <= bpm_nxt;
        level_r     <= level_nxt;
        buzz_r      <= buzz_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_r  <= in_tdata[SMP_W-1:0];
      time_r <= in_tdata[SMP_W +: TIME_W];
    end
    if (cmd.mul_ld) begin
      prod_r <= sum_r * RECIP;
    end
    if (cmd.decide) begin
      avg_r   <= avg_w;
      beat_r  <= beat_w;
      below_r <= below_w;
      delta_r <= time_r - last_time_r;
    end
    if (cmd.commit) begin
      out_user_r <= beat_r;
      out_data_r <= {2'b00, avg_r, buzz_nxt, level_nxt, bpm_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ src/ecg_bd_ctrl.sv @@
module ecg_bd_ctrl
  import ecg_bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  ecg_bd_sts_t sts,
  input  logic        div_done,
  output ecg_bd_cmd_t cmd
);

  ecg_bd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RING;
        end
      end
      S_RING: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_BRANCH;
      end
      S_BRANCH: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ src/ecg_beat_detector_unit.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_tvalid / in_tready   | in_tdata: sample, time_ms
// out     | output    | out_tvalid / out_tready | out_tdata: bpm, level, buzzer, average; tuser: beat
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A result beat is loaded after the ring update, mean, decision and branch states; a heartbeat
// whose interval is 1 to 65535 ms also waits on the serial BPM divider, which yields one quotient
// bit per cycle. A zero or longer interval needs no divide.
// The next input beat is taken in the cycle after the result is loaded into the output
// register; a result not yet taken stalls the block only when the next one is ready.
// Reset is synchronous and active low; never written ring entries read as zero.
module ecg_beat_detector_unit
  import ecg_bd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] sample, [39:8] time_ms
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] bpm, [12:8] heart_level,
                                            // [13] buzzer_on, [21:14] average_level,
                                            // [23:22] zero
  output logic                  out_tuser,  // [0] beat
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ecg_bd_cmd_t      cmd;
  ecg_bd_sts_t      sts;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;

  // Registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller steps one item through ring update, mean, decision,
  // optional divide and result commit.
  ecg_bd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .div_done (div_done),
    .cmd      (cmd)
  );

  // The datapath holds the ring, the detector state and the output register.
  ecg_bd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .div_den   (div_den),
    .div_quo   (div_quo),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // BPM divider: 60000 over the beat interval when it fits in 16 bits.
  ecg_bd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

`include "ecg_beat_detector_unit_assert.svh"

  // Only one item is in flight: an accepted beat closes the input at once.
  `ECG_BD_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready,
                      "input taken while busy")
  // A result is committed only into a free output register.
  `ECG_BD_ASSERT_SAME(a_commit_free, cmd.commit, sts.out_free, "result overwrote a pending beat")
  // The divider is started only when it is idle.
  `ECG_BD_ASSERT_SAME(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
  // A reported heartbeat always shows the top heart level.
  `ECG_BD_ASSERT_SAME(a_beat_level, out_tvalid && out_tuser,
                      out_tdata[12:8] == LEVEL_BEAT, "beat without top level")

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ecg_bd_pkg::*;

  // Run control. The watchdog limit covers the long receiver hold-off with a wide
  // margin, on top of the time a result takes and both sides' idle gaps.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_TAIL      = 40;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_GAP         = 9;

  // Indexes past the end of the register map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SOUND_ENABLED + 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  // One result as the detector should report it.
  typedef struct packed {
    logic                heartbeat;
    logic [BPM_W-1:0]    bpm;
    logic [LEVEL_W-1:0]  heart_level;
    logic                buzzer_on;
    logic [SMP_W-1:0]    average_level;
  } reading_t;

  // Layout of out_tdata, top bits first.
  typedef struct packed {
    logic [OUT_DATA_W-SMP_W-LEVEL_W-BPM_W-2:0] pad;
    logic [SMP_W-1:0]                          average_level;
    logic                                      buzzer_on;
    logic [LEVEL_W-1:0]                        heart_level;
    logic [BPM_W-1:0]                          bpm;
  } out_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] sample, [39:8] time_ms
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] bpm, [12:8] heart_level, [13] buzzer_on,
                                     // [21:14] average_level, [23:22] zero
  logic                  out_tuser;  // [0] beat
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecg_beat_detector_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Our own copy of the detector state and its two registers. Every accepted
  // input beat advances it by one sample.
  logic [SMP_W-1:0]    ring_copy [RING_DEPTH];
  int unsigned         ring_slot;
  int unsigned         ring_total;
  logic                armed_copy;
  logic [TIME_W-1:0]   last_beat_ms;
  logic [7:0]          idle_run;
  logic [BPM_W-1:0]    bpm_copy;
  logic [LEVEL_W-1:0]  level_copy;
  logic                buzzer_copy;
  logic [OFFSET_W-1:0] offset_copy;
  logic                sound_copy;

  // Readings predicted for accepted samples whose result beat has not come yet.
  reading_t pending_readings [$];
  int       error_count;

  // Knobs shared between the stimulus and the result checker.
  bit sender_gaps;
  bit receiver_gaps;
  int hold_request;

  // State of the synthetic ECG waveform: a noisy baseline with a sharp peak
  // every few samples, time stamps rising by a few milliseconds per sample.
  int                wave_base;
  int                wave_period;
  int                wave_pos;
  logic [TIME_W-1:0] wave_clock;

  // Advance the detector copy by one sample and return what the block must report.
  // The mean is taken over the whole ring, the new sample included. A heartbeat
  // needs the detector to be armed and the sample strictly above mean plus offset;
  // a sample strictly below the mean re-arms it and ages the display level.
  function automatic reading_t predict_reading(input logic [SMP_W-1:0]  smp,
                                               input logic [TIME_W-1:0] now);
    reading_t          r;
    int unsigned       mean;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] rate;
    ring_total           = ring_total - ring_copy[ring_slot] + smp;
    ring_copy[ring_slot] = smp;
    ring_slot            = (ring_slot + 1) % RING_DEPTH;
    mean                 = ring_total / RING_DEPTH;
    r                    = '0;
    if (armed_copy && smp > mean + offset_copy) begin
      // The interval wraps with the time stamp; a zero interval reads as the maximum.
      interval     = now - last_beat_ms;
      rate         = (interval == '0) ? TIME_W'(BPM_MAX) : TIME_W'(BPM_NUM) / interval;
      bpm_copy     = (rate > BPM_MAX) ? BPM_MAX : rate[BPM_W-1:0];
      level_copy   = LEVEL_BEAT;
      buzzer_copy  = sound_copy;
      last_beat_ms = now;
      idle_run     = '0;
      armed_copy   = 1'b0;
      r.heartbeat  = 1'b1;
    end else if (smp < mean) begin
      // The first idle samples only silence the buzzer; later ones dim the display.
      if (idle_run < IDLE_BUZZ_OFF) begin
        buzzer_copy = 1'b0;
      end else if (idle_run < IDLE_HIGH) begin
        level_copy = LEVEL_HIGH;
      end else if (idle_run < IDLE_MID) begin
        level_copy = LEVEL_MID;
      end else begin
        level_copy = LEVEL_LOW;
      end
      armed_copy = 1'b1;
      if (idle_run != IDLE_MAX) begin
        idle_run = idle_run + 8'd1;
      end
    end
    r.bpm           = bpm_copy;
    r.heart_level   = level_copy;
    r.buzzer_on     = buzzer_copy;
    r.average_level = mean[SMP_W-1:0];
    return r;
  endfunction

  // Offer one sample and hold it until the block takes it. The valid stays high
  // after the beat so that a back-to-back sample never lowers and raises it in the
  // same time step; whoever stops sending lowers it.
  task automatic send_sample(input logic [SMP_W-1:0] smp, input logic [TIME_W-1:0] now);
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(predict_reading(smp, now));
  endtask

  // Stop offering samples and wait until every outstanding result has arrived.
  // Each sample yields exactly one result, so the block is idle afterwards.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle. The valid is left high so
  // that two writes in a row keep it steady; the next sample lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_THRESHOLD_OFFSET) begin
      offset_copy = val;
    end else if (idx == REG_SOUND_ENABLED) begin
      sound_copy = val[0];
    end
  endtask

  // Mostly ECG-shaped samples, with some noise and some time stamps that jump
  // anywhere in the 32-bit range.
  task automatic send_ecg_items(input int count);
    int               kind;
    int               level;
    logic [SMP_W-1:0] smp;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        if (wave_pos >= wave_period) begin
          wave_pos = 0;
          smp      = SMP_W'($urandom_range(wave_base + 60, 255));
        end else begin
          wave_pos++;
          level = wave_base + int'($urandom_range(0, 24)) - 12;
          smp   = (level < 0) ? '0 : SMP_W'(level);
        end
        wave_clock = wave_clock + TIME_W'($urandom_range(0, 60));
      end else if (kind < 95) begin
        smp        = SMP_W'($urandom);
        wave_clock = wave_clock + TIME_W'($urandom_range(0, 5000));
      end else begin
        smp        = SMP_W'($urandom);
        wave_clock = TIME_W'($urandom);
      end
      send_sample(smp, wave_clock);
    end
  endtask

  // Straight out of reset with the reset register values: an all-zero sample
  // changes nothing, and a full-scale one at time zero is a heartbeat with a zero
  // interval while the sound is still off.
  task automatic test_reset_state();
    send_sample('0, '0);
    send_sample('1, '0);
  endtask

  // Pairs of an idle sample, which re-arms the detector, and a full-scale
  // heartbeat. The intervals walk through the saturation edge of the BPM, one
  // minute exactly, an interval too long to show and a wrap of the time stamp.
  task automatic test_bpm_extremes();
    logic [TIME_W-1:0] beat_times [6] = '{32'd1, 32'd236, 32'd472, 32'd60472,
                                          32'hFFFF_FFFF, 32'd399};
    write_reg(REG_SOUND_ENABLED, 8'h01);
    foreach (beat_times[i]) begin
      send_sample('0, beat_times[i]);
      send_sample('1, beat_times[i]);
    end
  endtask

  // Writes past the register map must leave both registers alone. A heartbeat at
  // the same time stamp as the previous one then still sounds the buzzer and still
  // needs the old offset.
  task automatic test_unused_indexes();
    write_reg(REG_FIRST_UNUSED, '0);
    write_reg(REG_LAST_UNUSED, '0);
    send_sample('0, 32'd399);
    send_sample('1, 32'd399);
  endtask

  // A run of idle samples after a heartbeat: the buzzer goes quiet first, then
  // the display level steps down through all three lower values.
  task automatic test_idle_decay();
    for (int i = 0; i < 9; i++) begin
      send_sample('0, 32'd1000 + TIME_W'(i));
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming with no
  // gaps, so the block fills up and has to stall its input.
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    send_ecg_items(48);
    sender_gaps  = 1'b1;
  endtask

  // The sender stops until every result is back and then starts again.
  task automatic test_drain_pause();
    send_ecg_items(24);
    wait_drained();
    send_ecg_items(24);
  endtask

  // Random traffic in phases. Each phase picks a register setting, a fresh
  // waveform and whether either side idles. The offset also takes both of its
  // extremes; at full offset no heartbeat is possible, so that long phase drives
  // the idle count into saturation.
  task automatic test_random_traffic(input int total);
    int                  sent;
    int                  phase;
    int                  chunk;
    logic [OFFSET_W-1:0] offset;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      case (phase % 5)
        0: begin
          offset = '0;
        end
        1: begin
          offset = '1;
        end
        2: begin
          offset = OFFSET_RESET;
        end
        default: begin
          offset = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom)
                                               : OFFSET_W'($urandom_range(0, 80));
        end
      endcase
      write_reg(REG_THRESHOLD_OFFSET, offset);
      write_reg(REG_SOUND_ENABLED, CFG_DATA_W'($urandom));
      wave_base     = $urandom_range(10, 150);
      wave_period   = $urandom_range(4, 40);
      wave_pos      = 0;
      sender_gaps   = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      chunk         = (offset == '1) ? 400 : $urandom_range(60, 160);
      send_ecg_items(chunk);
      sent  += chunk;
      phase++;
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Result side: take each result beat, compare it field by field with the oldest
  // prediction, then draw how long to hold off before the next one. A hold-off
  // request from the stimulus takes precedence over the random gaps.
  initial begin : result_checker
    reading_t  want;
    out_word_t got;
    logic      took;
    int        stall;
    do @(posedge clk); while (!rst_n);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      took = out_tvalid && out_tready;
      if (took) begin
        got = out_word_t'(out_tdata);
        if (pending_readings.size() == 0) begin
          $error("result beat with no reading pending");
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          if (out_tuser !== want.heartbeat) begin
            $error("beat: expected %0d, got %0d", want.heartbeat, out_tuser);
            error_count++;
          end
          if (got.bpm !== want.bpm) begin
            $error("bpm: expected %0d, got %0d", want.bpm, got.bpm);
            error_count++;
          end
          if (got.heart_level !== want.heart_level) begin
            $error("heart_level: expected %0d, got %0d", want.heart_level,
                   got.heart_level);
            error_count++;
          end
          if (got.buzzer_on !== want.buzzer_on) begin
            $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, got.buzzer_on);
            error_count++;
          end
          if (got.average_level !== want.average_level) begin
            $error("average_level: expected %0d, got %0d", want.average_level,
                   got.average_level);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else if (took && receiver_gaps) begin
        stall = $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Ends the run when no beat has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset once, the directed checks, the pressure checks, then
  // random traffic. The run ends after every result is back and a short tail in
  // which any stray result beat would still be caught.
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    hold_request  = 0;
    error_count   = 0;
    // The detector copy starts from the reset state and the reset register values.
    foreach (ring_copy[i]) begin
      ring_copy[i] = '0;
    end
    ring_slot    = 0;
    ring_total   = 0;
    armed_copy   = 1'b1;
    last_beat_ms = '0;
    idle_run     = '0;
    bpm_copy     = '0;
    level_copy   = '0;
    buzzer_copy  = 1'b0;
    offset_copy  = OFFSET_RESET;
    sound_copy   = 1'b0;
    wave_base    = 60;
    wave_period  = 20;
    wave_pos     = 0;
    wave_clock   = TIME_W'($urandom);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_bpm_extremes();
    test_unused_indexes();
    test_idle_decay();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
